@@ sv/tedr_pkg.sv @@
package tedr_pkg;

    // Field widths fixed by the interface
    localparam int unsigned LETTER_W   = 8;
    localparam int unsigned DEPTH_W    = 6;
    localparam int unsigned ENTRY_W    = 6;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned QREGS      = 4;
    localparam int unsigned QIDX_W     = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CHARS0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CHARS1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CHARS2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CHARS3 = 3'd5;

    localparam logic [ENTRY_W-1:0] MAX_COST_RST = 6'd2;
    localparam logic [ENTRY_W-1:0] ENTRY_SAT    = 6'd63;

    typedef struct packed {
        logic [LETTER_W-1:0] edge_letter;
        logic [DEPTH_W-1:0]  node_depth;
        logic                ends_word;
    } in_item_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] distance;
        logic               word_match;
        logic [ENTRY_W-1:0] row_minimum;
        logic               descend;
    } out_item_t;

    // Operands of one row cell
    typedef struct packed {
        logic                first_col;
        logic [ENTRY_W-1:0]  prev_diag;
        logic [ENTRY_W-1:0]  prev_up;
        logic [ENTRY_W-1:0]  cur_left;
        logic [LETTER_W-1:0] query_char;
        logic [LETTER_W-1:0] letter;
    } cell_op_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_PREP,
        SEQ_RUN,
        SEQ_FINISH
    } seq_state_t;

endpackage

@@ sv/tedr_row_mem.sv @@
module tedr_row_mem #(
    parameter int unsigned ENTRIES = 1056,
    parameter int unsigned ADDR_W  = 11
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [tedr_pkg::ENTRY_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [tedr_pkg::ENTRY_W-1:0] rd_data
);
    import tedr_pkg::*;

    logic [ENTRY_W-1:0] mem [ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/tedr_cell.sv @@
module tedr_cell (
    input  tedr_pkg::cell_op_t           op,
    output logic [tedr_pkg::ENTRY_W-1:0] cur
);
    import tedr_pkg::*;

    logic [ENTRY_W:0] up_cost;
    logic [ENTRY_W:0] left_cost;
    logic [ENTRY_W:0] diag_cost;
    logic [ENTRY_W:0] min_a;
    logic [ENTRY_W:0] min_b;

    // Deletion, insertion and substitution costs
    always_comb
    begin
        up_cost   = {1'b0, op.prev_up} + (ENTRY_W+1)'(1);
        left_cost = {1'b0, op.cur_left} + (ENTRY_W+1)'(1);
        diag_cost = {1'b0, op.prev_diag} + {{ENTRY_W{1'b0}}, (op.query_char != op.letter)};
    end

    // Minimum of three, column zero takes only the up cost; saturate to entry width
    always_comb
    begin
        min_a = (left_cost < up_cost) ? left_cost : up_cost;
        min_b = (diag_cost < min_a) ? diag_cost : min_a;
        if (op.first_col)
        begin
            min_b = up_cost;
        end
        cur = min_b[ENTRY_W] ? ENTRY_SAT : min_b[ENTRY_W-1:0];
    end

endmodule

@@ sv/trie_edit_distance_row_engine.sv @@
// Levenshtein row engine for a trie search.
// Software walks the trie in preorder and sends one transaction per node visit on
// the item channel (edge letter, depth, word-end flag). The block computes that
// node's edit-distance row against the query from the row stored at depth minus
// one (implicit row 0..length at depth one), stores the new row at its depth and
// returns one transaction on the result channel: distance, word match, row minimum
// and descend flag.
// Configuration (query length, max cost, query characters) is written over the cfg
// channel, which is always ready; the user must write it only while no item is in
// flight, as the block itself does not enforce this. An accepted item passes a prep
// state, then a run state computing one row cell per cycle in the shared cell unit
// over all MAX_QUERY_LEN+1 columns, fed by the single read port of the row memory,
// then a finish state that loads the result; only then is a new item accepted.
// A finished result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls and a second result is done, the engine holds it
// until the register frees.
// Reset clears control state and the configuration (max cost resets to 2); the row
// memory is not cleared, rows are undefined until a visit writes them.
module trie_edit_distance_row_engine #(
    parameter int unsigned MAX_QUERY_LEN = 32,
    parameter int unsigned MAX_DEPTH     = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  tedr_pkg::in_item_t             item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output tedr_pkg::out_item_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tedr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tedr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tedr_pkg::*;

    localparam int unsigned NCOLS   = MAX_QUERY_LEN + 1;
    localparam int unsigned ENTRIES = MAX_DEPTH * NCOLS;
    localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned COL_W   = $clog2(NCOLS + 1);
    localparam int unsigned DEP_W   = $clog2(MAX_DEPTH + 1);

    // Configuration registers
    logic [ENTRY_W-1:0]               query_length_reg;
    logic [ENTRY_W-1:0]               max_cost_reg;
    logic [QREGS-1:0][CFG_DATA_W-1:0] query_chars_reg;

    // Sequencer and datapath registers
    seq_state_t          state_reg, state_next;
    logic [COL_W-1:0]    col_reg;
    logic                result_valid_reg;
    logic [LETTER_W-1:0] letter_reg;
    logic                ends_reg;
    logic                first_reg;
    logic [ADDR_W-1:0]   wr_base_reg;
    logic [ADDR_W-1:0]   rd_base_reg;
    logic [ENTRY_W-1:0]  prev_left_reg;
    logic [ENTRY_W-1:0]  cur_left_reg;
    logic [ENTRY_W-1:0]  rmin_reg;
    logic [ENTRY_W-1:0]  dist_reg;
    out_item_t           result_reg;

    logic                item_fire;
    logic                load_result;
    logic                last_col;
    logic [DEP_W-1:0]    dep_sat;
    logic [ADDR_W-1:0]   wr_base_calc;
    logic [ADDR_W-1:0]   rd_base_calc;
    logic [COL_W-1:0]    len_sat;
    logic [QIDX_W-1:0]   qidx;
    logic [LETTER_W-1:0] qchar;
    logic [ENTRY_W-1:0]  prev_up;
    logic [ENTRY_W-1:0]  cell_cur;
    cell_op_t            cell_op;

    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic                mem_rd_en;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic [ENTRY_W-1:0]  mem_rd_data;

    assign cfg_ready    = 1'b1;
    assign item_fire    = item_valid && item_ready;
    assign last_col     = (col_reg == COL_W'(NCOLS - 1));
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_length_reg <= '0;
            max_cost_reg     <= MAX_COST_RST;
            query_chars_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_QUERY_LENGTH: query_length_reg   <= cfg_data[ENTRY_W-1:0];
                CFG_MAX_COST:     max_cost_reg       <= cfg_data[ENTRY_W-1:0];
                CFG_QUERY_CHARS0: query_chars_reg[0] <= cfg_data;
                CFG_QUERY_CHARS1: query_chars_reg[1] <= cfg_data;
                CFG_QUERY_CHARS2: query_chars_reg[2] <= cfg_data;
                CFG_QUERY_CHARS3: query_chars_reg[3] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Depth clamp and row base addresses for an incoming visit
    always_comb
    begin
        if (item.node_depth == '0)
        begin
            dep_sat = DEP_W'(1);
        end
        else if (32'(item.node_depth) > MAX_DEPTH)
        begin
            dep_sat = DEP_W'(MAX_DEPTH);
        end
        else
        begin
            dep_sat = DEP_W'(item.node_depth);
        end
        wr_base_calc = ADDR_W'((32'(dep_sat) - 32'd1) * NCOLS);
        rd_base_calc = ADDR_W'(wr_base_calc - ADDR_W'(NCOLS));
    end

    // Clamped query length
    assign len_sat = (32'(query_length_reg) > MAX_QUERY_LEN) ?
                     COL_W'(MAX_QUERY_LEN) : COL_W'(query_length_reg);

    // Query character for the current column (index col - 1)
    always_comb
    begin
        qidx  = QIDX_W'(col_reg - COL_W'(1));
        qchar = query_chars_reg[qidx[QIDX_W-1:3]][{qidx[2:0], 3'b000} +: LETTER_W];
    end

    // Previous row entry: implicit row at depth one, memory otherwise
    assign prev_up = first_reg ? ENTRY_W'(col_reg) : mem_rd_data;

    always_comb
    begin
        cell_op.first_col  = (col_reg == '0);
        cell_op.prev_diag  = prev_left_reg;
        cell_op.prev_up    = prev_up;
        cell_op.cur_left   = cur_left_reg;
        cell_op.query_char = qchar;
        cell_op.letter     = letter_reg;
    end

    tedr_cell u_cell (
        .op  (cell_op),
        .cur (cell_cur)
    );

    tedr_row_mem #(
        .ENTRIES (ENTRIES),
        .ADDR_W  (ADDR_W)
    ) u_row_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (cell_cur),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = SEQ_PREP;
                end
            end
            SEQ_PREP:
            begin
                state_next = SEQ_RUN;
            end
            SEQ_RUN:
            begin
                if (last_col)
                begin
                    state_next = SEQ_FINISH;
                end
            end
            SEQ_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        item_ready  = 1'b0;
        load_result = 1'b0;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_addr = ADDR_W'(wr_base_reg + ADDR_W'(col_reg));
        mem_rd_addr = rd_base_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                item_ready = 1'b1;
            end
            SEQ_PREP:
            begin
                mem_rd_en = !first_reg;
            end
            SEQ_RUN:
            begin
                mem_wr_en   = 1'b1;
                mem_rd_en   = !first_reg && !last_col;
                mem_rd_addr = ADDR_W'(rd_base_reg + ADDR_W'(col_reg) + ADDR_W'(1));
            end
            SEQ_FINISH:
            begin
                load_result = !result_valid_reg || result_ready;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= SEQ_IDLE;
            col_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SEQ_PREP)
            begin
                col_reg <= '0;
            end
            else if (state_reg == SEQ_RUN)
            begin
                col_reg <= COL_W'(col_reg + COL_W'(1));
            end
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Visit operands, running row values and the result register
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            letter_reg  <= item.edge_letter;
            ends_reg    <= item.ends_word;
            first_reg   <= (dep_sat == DEP_W'(1));
            wr_base_reg <= wr_base_calc;
            rd_base_reg <= rd_base_calc;
        end
        if (state_reg == SEQ_RUN)
        begin
            prev_left_reg <= prev_up;
            cur_left_reg  <= cell_cur;
            if (col_reg == '0)
            begin
                rmin_reg <= cell_cur;
            end
            else if ((col_reg <= len_sat) && (cell_cur < rmin_reg))
            begin
                rmin_reg <= cell_cur;
            end
            if (col_reg == len_sat)
            begin
                dist_reg <= cell_cur;
            end
        end
        if (load_result)
        begin
            result_reg.distance    <= dist_reg;
            result_reg.word_match  <= ends_reg && (dist_reg <= max_cost_reg);
            result_reg.row_minimum <= rmin_reg;
            result_reg.descend     <= (rmin_reg <= max_cost_reg);
        end
    end

    // Read and write never hit the same row entry
    a_mem_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("row memory read and write collide");

    // Column counter stays inside the row
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_RUN) |-> (32'(col_reg) < NCOLS))
        else $error("column counter out of range");

    // Row sweep leaves only after the last column
    a_run_complete: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == SEQ_RUN) && !last_col) |=> (state_reg == SEQ_RUN))
        else $error("row sweep ended early");

    // Row minimum never exceeds the distance at the query-length column
    a_min_le_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_FINISH) |-> (rmin_reg <= dist_reg))
        else $error("row minimum above distance");

endmodule
